>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the ranger rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// types and constants of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

   // width of the echo pulse counter, 16 to 32
   localparam int CountBits = 24;

   localparam int EchoW     = 24;
   localparam int DistW     = 16;
   localparam int CfgW      = 16;
   localparam int ScaleFrac = 24;
   localparam int ProdBits  = CountBits + CfgW;

   localparam logic [EchoW-1:0] EchoMax = {EchoW{1'b1}};
   localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

   // register file port
   localparam int AddrW = 4;
   localparam int DataW = 32;
   localparam int IdxW  = 2;

   localparam logic [IdxW-1:0] RegTriggerTicks = 2'd0;
   localparam logic [IdxW-1:0] RegCmScale      = 2'd1;
   localparam logic [IdxW-1:0] RegNearLimit    = 2'd2;

   localparam logic [CfgW-1:0] TriggerTicksRst = 16'd80;
   localparam logic [CfgW-1:0] CmScaleRst      = 16'd17983;
   localparam logic [CfgW-1:0] NearLimitRst    = 16'd10;

   typedef enum logic [1:0] {
      PhTrigger  = 2'd0,
      PhWaitRise = 2'd1,
      PhMeasure  = 2'd2
   } phase_type;

endpackage

>>> hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// trigger pulse, echo edge wait and echo pulse timing with distance and
// near flag, one echo sample per beat
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  req      in         req_valid / req_stall      req_echo_level
//  rsp      out        rsp_valid / rsp_stall      rsp_trigger_level, rsp_measure_done,
//                                                 rsp_echo_ticks, rsp_distance_cm,
//                                                 rsp_near_flag
//  csr      in         psel / penable / pready    paddr, pwdata, pwrite, prdata
//
//  one beat in, one beat out; a sample can be taken every cycle while req_stall is low
//  the result is registered and ready in the cycle after the sample is taken; the path is one
//  24x16 multiply followed by the saturate and the near compare
//  req_stall is high only while a result is held and rsp_stall is high
//  synchronous reset: trigger phase, counters and last results cleared,
//  registers back to their defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_ranger (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_echo_level,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_trigger_level,
   output logic                           rsp_measure_done,
   output logic [uer_pkg::EchoW-1:0]      rsp_echo_ticks,
   output logic [uer_pkg::DistW-1:0]      rsp_distance_cm,
   output logic                           rsp_near_flag,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [uer_pkg::AddrW-1:0]      paddr,
   input  logic [uer_pkg::DataW-1:0]      pwdata,
   output logic [uer_pkg::DataW-1:0]      prdata,
   output logic                           pready
);

   // configuration registers
   logic [uer_pkg::CfgW-1:0] trigger_ticks_ff;
   logic [uer_pkg::CfgW-1:0] cm_scale_ff;
   logic [uer_pkg::CfgW-1:0] near_limit_ff;
   logic [uer_pkg::IdxW-1:0] csr_idx;
   logic                     csr_wr;

   // ranging state
   uer_pkg::phase_type            phase_ff, phase_in;
   logic [uer_pkg::CountBits-1:0] tick_count_ff, tick_count_in;
   logic                          prev_echo_ff;

   // result register, the payload fields also hold the last measurement
   logic                          rsp_valid_ff;
   logic                          trigger_ff, trigger_in;
   logic                          done_ff, done_in;
   logic [uer_pkg::EchoW-1:0]     echo_ticks_ff;
   logic [uer_pkg::DistW-1:0]     distance_ff;
   logic                          near_ff;

   logic                          req_accept;
   logic [uer_pkg::CountBits-1:0] count_sat_inc;
   logic [uer_pkg::CountBits-1:0] trig_len;
   logic [uer_pkg::ProdBits-1:0]  product;
   logic [uer_pkg::ProdBits-uer_pkg::ScaleFrac-1:0] product_cm;
   logic [uer_pkg::EchoW-1:0]     echo_ticks_meas;
   logic [uer_pkg::DistW-1:0]     distance_meas;
   logic                          near_meas;

   // ---------------------------------------------------------------- csr port
   assign pready = 1'b1;
   assign csr_idx = paddr[uer_pkg::AddrW-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= uer_pkg::TriggerTicksRst;
         cm_scale_ff      <= uer_pkg::CmScaleRst;
         near_limit_ff    <= uer_pkg::NearLimitRst;
      end else if (csr_wr) begin
         case (csr_idx)
            uer_pkg::RegTriggerTicks: trigger_ticks_ff <= pwdata[uer_pkg::CfgW-1:0];
            uer_pkg::RegCmScale:      cm_scale_ff      <= pwdata[uer_pkg::CfgW-1:0];
            uer_pkg::RegNearLimit:    near_limit_ff    <= pwdata[uer_pkg::CfgW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         uer_pkg::RegTriggerTicks: prdata = uer_pkg::DataW'(trigger_ticks_ff);
         uer_pkg::RegCmScale:      prdata = uer_pkg::DataW'(cm_scale_ff);
         uer_pkg::RegNearLimit:    prdata = uer_pkg::DataW'(near_limit_ff);
         default:                  prdata = '0;
      endcase
   end

   // -------------------------------------------------------------- handshake
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------ measurement
   assign count_sat_inc = (&tick_count_ff) ? tick_count_ff
                                           : tick_count_ff + uer_pkg::CountBits'(1);
   assign trig_len = (trigger_ticks_ff == '0) ? uer_pkg::CountBits'(1)
                                              : uer_pkg::CountBits'(trigger_ticks_ff);

   assign product    = uer_pkg::ProdBits'(tick_count_ff) * uer_pkg::ProdBits'(cm_scale_ff);
   assign product_cm = product[uer_pkg::ProdBits-1:uer_pkg::ScaleFrac];

   assign echo_ticks_meas = (tick_count_ff > uer_pkg::CountBits'(uer_pkg::EchoMax))
                            ? uer_pkg::EchoMax : uer_pkg::EchoW'(tick_count_ff);
   assign distance_meas   = (product_cm > uer_pkg::DistMax)
                            ? uer_pkg::DistMax : uer_pkg::DistW'(product_cm);
   assign near_meas       = (distance_meas <= near_limit_ff);

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      trigger_in    = 1'b0;
      done_in       = 1'b0;
      case (phase_ff)
         uer_pkg::PhWaitRise: begin
            if (req_echo_level && !prev_echo_ff) begin
               phase_in      = uer_pkg::PhMeasure;
               tick_count_in = uer_pkg::CountBits'(1);
            end
         end
         uer_pkg::PhMeasure: begin
            if (req_echo_level) begin
               tick_count_in = count_sat_inc;
            end else begin
               done_in       = 1'b1;
               phase_in      = uer_pkg::PhTrigger;
               tick_count_in = '0;
            end
         end
         default: begin
            trigger_in    = 1'b1;
            phase_in      = uer_pkg::PhTrigger;
            tick_count_in = count_sat_inc;
            if (count_sat_inc >= trig_len) begin
               phase_in      = uer_pkg::PhWaitRise;
               tick_count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= uer_pkg::PhTrigger;
         tick_count_ff <= '0;
         prev_echo_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         prev_echo_ff  <= req_echo_level;
      end
   end

   // ---------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         trigger_ff    <= 1'b0;
         done_ff       <= 1'b0;
         echo_ticks_ff <= '0;
         distance_ff   <= '0;
         near_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
            trigger_ff   <= trigger_in;
            done_ff      <= done_in;
            if (done_in) begin
               echo_ticks_ff <= echo_ticks_meas;
               distance_ff   <= distance_meas;
               near_ff       <= near_meas;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = trigger_ff;
   assign rsp_measure_done  = done_ff;
   assign rsp_echo_ticks    = echo_ticks_ff;
   assign rsp_distance_cm   = distance_ff;
   assign rsp_near_flag     = near_ff;

   // ------------------------------------------------------------- assertions
   `ASSERT_ALWAYS(a_trig_done_excl, !(rsp_valid_ff && trigger_ff && done_ff))
   `ASSERT_ALWAYS(a_wait_count_zero, (phase_ff != uer_pkg::PhWaitRise) || (tick_count_ff == '0))
   `ASSERT_NEXT(a_fall_ends_measure, req_accept && (phase_ff == uer_pkg::PhMeasure) && !req_echo_level, rsp_valid_ff && done_ff && (phase_ff == uer_pkg::PhTrigger))
   `ASSERT_NEXT(a_measure_counts, req_accept && (phase_ff == uer_pkg::PhWaitRise) && req_echo_level && !prev_echo_ff, (phase_ff == uer_pkg::PhMeasure) && (tick_count_ff == uer_pkg::CountBits'(1)))

endmodule
